### hw/rtl/assert_macros.svh
// Assertion macros for the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("property violated");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### hw/rtl/ttt_pkg.sv
// Types, constants and score helpers of the two-tier transposition table
package ttt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 4096;
   localparam int unsigned MAX_DEPTH = 64;
   localparam logic [8:0] DEPTH_CAP = 9'(MAX_DEPTH - 1);
   localparam logic [14:0] MATE_RESET = 15'd29000;

   localparam logic [1:0] ACT_PROBE = 2'd0;
   localparam logic [1:0] ACT_STORE = 2'd1;
   localparam logic [1:0] ACT_MOVE  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] FLAG_NONE  = 2'd0;
   localparam logic [1:0] FLAG_UPPER = 2'd1;
   localparam logic [1:0] FLAG_LOWER = 2'd2;
   localparam logic [1:0] FLAG_EXACT = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [63:0]        key;
      logic [5:0]         ply;
      logic [5:0]         depth;
      logic signed [15:0] alpha;
      logic signed [15:0] beta;
      logic [31:0]        move_in;
      logic signed [15:0] score_in;
      logic [1:0]         flag_in;
   } req_type;

   typedef struct packed {
      logic               move_found;
      logic [31:0]        move_out;
      logic               usable;
      logic signed [15:0] score_out;
      logic [31:0]        hit_count;
      logic [31:0]        new_write_count;
      logic [31:0]        over_write_count;
   } rsp_type;

   typedef struct packed {
      logic [5:0]  depth;
      logic [1:0]  flag;
      logic [15:0] score;
      logic [31:0] move;
   } entry_type;

   typedef struct packed {
      logic [63:0] key;
      entry_type   entry;
   } slot_type;

   localparam int unsigned SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic accept;
      logic clear_start;
      logic access;
      logic sweep;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
   } sts_type;

   function automatic logic signed [15:0] clamp_score(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sd32767;
      end else if (v < -18'sd32767) begin
         r = -16'sd32767;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [5:0] sat_depth(input logic [5:0] d);
      return ({3'b000, d} > DEPTH_CAP) ? DEPTH_CAP[5:0] : d;
   endfunction

endpackage

### hw/rtl/two_tier_transposition_table.sv
// Top level of the two-tier transposition table
// A probe, move-only probe or store is taken when start is high and busy is low; it reads
// both table slots in the cycle of the transfer, and in the next cycle the datapath decides,
// writes the slots back and loads the result, raising the result strobe rsp_valid with it;
// busy stays high until then, so no new command is taken before the last one is through. A
// clear sweeps both tables one entry per cycle and strobes its result at the end; the same
// sweep runs after reset, with no result, and busy stays high throughout. The result stays
// on rsp_item until the next command changes it, but its strobe rsp_valid is high for exactly
// one cycle and cannot be held off: capture it when rsp_valid is high. The mate threshold
// register may be written at any cycle (csr_ready is always high) but should change only while the block is idle.
module two_tier_transposition_table #(
   parameter int unsigned TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttt_pkg::req_type  req_item,
   output logic              rsp_valid,
   output ttt_pkg::rsp_type  rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [14:0]       csr_data
);
   import ttt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   ttt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .action    (req_item.action),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ttt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );
endmodule

### hw/rtl/ttt_ram.sv
// Generic single-write, single-read RAM with registered read data
module ttt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/ttt_ctrl.sv
// Controller state machine: clearing sweep, idle and table access
`include "assert_macros.svh"
module ttt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        action,
   input  ttt_pkg::sts_type  sts,
   output ttt_pkg::cmd_type  cmd,
   output logic              busy,
   output logic              rsp_valid
);
   import ttt_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_ACCESS = 3'b100
   } state_type;

   state_type st_ff, st_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic sweep_end;

   assign accept    = start && (st_ff == ST_IDLE);
   assign sweep_end = (st_ff == ST_SWEEP) && sts.sweep_last;

   always_comb begin
      cmd.accept      = accept && (action != ACT_CLEAR);
      cmd.clear_start = accept && (action == ACT_CLEAR);
      cmd.access      = (st_ff == ST_ACCESS);
      cmd.sweep       = (st_ff == ST_SWEEP);
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_SWEEP: begin
            if (sts.sweep_last) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               st_in = (action == ACT_CLEAR) ? ST_SWEEP : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in      = cmd.clear_start ? 1'b1 : (sweep_end ? 1'b0 : pend_ff);
   assign rsp_valid_in = cmd.access || (sweep_end && pend_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_SWEEP;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (st_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_PROP(a_accept_busy, clock, reset, start && st_ff == ST_IDLE |=> st_ff != ST_IDLE)
   `ASSERT_PROP(a_access_rsp, clock, reset, st_ff == ST_ACCESS |=> rsp_valid_ff)
   `ASSERT_NEVER(a_rsp_idle, clock, reset, rsp_valid_ff && st_ff != ST_IDLE)
endmodule

### hw/rtl/ttt_datapath.sv
// Datapath: both tables, score adjustment, cutoff test, counters, result register
module ttt_datapath #(
   parameter int unsigned TABLE_ENTRIES = ttt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ttt_pkg::req_type  req_item,
   input  logic              csr_we,
   input  logic [14:0]       csr_data,
   input  ttt_pkg::cmd_type  cmd,
   output ttt_pkg::sts_type  sts,
   output ttt_pkg::rsp_type  rsp_item
);
   import ttt_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

   logic [14:0]      thr_ff;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [IDX_W-1:0] sweep_addr_ff;
   logic [31:0]      hits_ff, hits_in;
   logic [31:0]      fresh_ff, fresh_in;
   logic [31:0]      repl_ff, repl_in;

   logic [SLOT_W-1:0] at_rdata, dp_rdata, at_wdata, dp_wdata;
   logic [IDX_W-1:0]  wr_addr;
   logic              at_we, dp_we;
   slot_type          at_slot, dp_slot, new_slot;

   logic               is_store, is_probe, is_move;
   logic [5:0]         depth_sat;
   logic signed [17:0] thr18, ply18, sin18, sst18, pro18;
   logic signed [15:0] store_score, probe_score, cut_score;
   logic               fresh, replace;
   logic               at_hit, dp_hit, match, deep_enough, cut_ok;
   entry_type          hit_e;

   ttt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_always_ram (
      .clock (clock),
      .we    (at_we),
      .waddr (wr_addr),
      .wdata (at_wdata),
      .re    (cmd.accept),
      .raddr (req_item.key[IDX_W-1:0]),
      .rdata (at_rdata)
   );

   ttt_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_deep_ram (
      .clock (clock),
      .we    (dp_we),
      .waddr (wr_addr),
      .wdata (dp_wdata),
      .re    (cmd.accept),
      .raddr (req_item.key[IDX_W-1:0]),
      .rdata (dp_rdata)
   );

   assign at_slot = slot_type'(at_rdata);
   assign dp_slot = slot_type'(dp_rdata);

   assign is_store  = (req_ff.action == ACT_STORE);
   assign is_probe  = (req_ff.action == ACT_PROBE);
   assign is_move   = (req_ff.action == ACT_MOVE);
   assign depth_sat = sat_depth(req_ff.depth);
   assign thr18     = $signed({3'b000, thr_ff});
   assign ply18     = $signed({12'd0, req_ff.ply});

   always_comb begin
      sin18 = $signed({{2{req_ff.score_in[15]}}, req_ff.score_in});
      if (sin18 > thr18) begin
         sst18 = sin18 + ply18;
      end else if (sin18 < -thr18) begin
         sst18 = sin18 - ply18;
      end else begin
         sst18 = sin18;
      end
      store_score = clamp_score(sst18);
   end

   always_comb begin
      new_slot.key         = req_ff.key;
      new_slot.entry.depth = depth_sat;
      new_slot.entry.flag  = req_ff.flag_in;
      new_slot.entry.score = store_score;
      new_slot.entry.move  = req_ff.move_in;
   end

   assign fresh   = (at_slot.key == 64'd0);
   assign replace = !fresh && (dp_slot.entry.depth <= depth_sat);

   assign wr_addr  = cmd.sweep ? sweep_addr_ff : req_ff.key[IDX_W-1:0];
   assign at_we    = cmd.sweep || (cmd.access && is_store);
   assign dp_we    = cmd.sweep || (cmd.access && is_store && (fresh || replace));
   assign at_wdata = cmd.sweep ? '0 : new_slot;
   assign dp_wdata = cmd.sweep ? '0 : new_slot;

   assign at_hit      = (at_slot.key == req_ff.key);
   assign dp_hit      = (dp_slot.key == req_ff.key);
   assign match       = at_hit || dp_hit;
   assign hit_e       = at_hit ? at_slot.entry : dp_slot.entry;
   assign deep_enough = is_probe && match && (hit_e.depth >= depth_sat);

   always_comb begin
      pro18 = $signed({{2{hit_e.score[15]}}, hit_e.score});
      if (pro18 > thr18) begin
         probe_score = clamp_score(pro18 - ply18);
      end else if (pro18 < -thr18) begin
         probe_score = clamp_score(pro18 + ply18);
      end else begin
         probe_score = pro18[15:0];
      end
   end

   always_comb begin
      cut_ok    = 1'b0;
      cut_score = probe_score;
      case (hit_e.flag)
         FLAG_EXACT: begin
            cut_ok = 1'b1;
         end
         FLAG_UPPER: begin
            if (probe_score <= req_ff.alpha) begin
               cut_ok    = 1'b1;
               cut_score = req_ff.alpha;
            end
         end
         FLAG_LOWER: begin
            if (probe_score >= req_ff.beta) begin
               cut_ok    = 1'b1;
               cut_score = req_ff.beta;
            end
         end
         default: begin
            cut_ok = 1'b0;
         end
      endcase
   end

   assign hits_in  = hits_ff + {31'd0, deep_enough};
   assign fresh_in = fresh_ff + {31'd0, is_store && fresh};
   assign repl_in  = repl_ff + {31'd0, is_store && replace};

   always_comb begin
      rsp_in.move_found       = (is_probe || is_move) && match;
      rsp_in.move_out         = ((is_probe || is_move) && match) ? hit_e.move : 32'd0;
      rsp_in.usable           = deep_enough && cut_ok;
      rsp_in.score_out        = deep_enough ? cut_score : 16'sd0;
      rsp_in.hit_count        = hits_in;
      rsp_in.new_write_count  = fresh_in;
      rsp_in.over_write_count = repl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= MATE_RESET;
         sweep_addr_ff <= '0;
         hits_ff       <= 32'd0;
         fresh_ff      <= 32'd0;
         repl_ff       <= 32'd0;
      end else begin
         if (csr_we) begin
            thr_ff <= csr_data;
         end
         if (cmd.clear_start) begin
            sweep_addr_ff <= '0;
            hits_ff       <= 32'd0;
            fresh_ff      <= 32'd0;
            repl_ff       <= 32'd0;
         end else if (cmd.sweep) begin
            sweep_addr_ff <= sweep_addr_ff + IDX_W'(1);
         end else if (cmd.access) begin
            hits_ff  <= hits_in;
            fresh_ff <= fresh_in;
            repl_ff  <= repl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_item;
      end
      if (cmd.clear_start) begin
         rsp_ff <= '0;
      end else if (cmd.access) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.sweep_last = &sweep_addr_ff;
   assign rsp_item       = rsp_ff;
endmodule
